FILE: sv/lpuic_pkg.sv
// shared types and constants for the label pair id counter
// no dependencies; used by lpuic_ctrl, lpuic_dp and the top level
`default_nettype none

package lpuic_pkg;

   localparam int LABEL_W    = 32;
   localparam int COUNT_W    = 31;
   localparam int FACE_ID_W  = 9;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;

   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 104;
   localparam int RSP_USER_W = 3;

   localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNASSIGNED = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [FACE_ID_W-1:0] face_id;
      logic [LABEL_W-1:0]   lower_label;
      logic [LABEL_W-1:0]   upper_label;
      logic [COUNT_W-1:0]   triangle_count;
      logic                 is_new;
      logic [STATUS_W-1:0]  status;
   } result_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture item, start probe at its hash slot
      logic res_zero;    // all-zero result
      logic probe_next;  // step to next hash slot
      logic insert;      // new pair: write slot and entry, bump next id
      logic drop;        // new pair with the table full
      logic bump;        // known pair: raise count
      logic read_res;    // result from an entry read
      logic sweep;       // clear one hash slot
      logic reset_ids;   // next id back to one
      logic out_load;    // move result into the output register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [CMD_W-1:0] item_cmd;
      logic             slot_empty;
      logic             key_match;
      logic             table_full;
      logic             sweep_last;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: sv/lpuic_ctrl.sv
// controller state machine for the label pair id counter
// depends on lpuic_pkg; drives lpuic_dp through ctrl_cmd_type
`default_nettype none

module lpuic_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   input  lpuic_pkg::dp_status_type status,
   output lpuic_pkg::ctrl_cmd_type  ctrl
);

   localparam logic [2:0] S_INIT     = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_SLOT_RD  = 3'd2;
   localparam logic [2:0] S_SLOT_CHK = 3'd3;
   localparam logic [2:0] S_KEY_CHK  = 3'd4;
   localparam logic [2:0] S_READ     = 3'd5;
   localparam logic [2:0] S_CLEAR    = 3'd6;
   localparam logic [2:0] S_DONE     = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      ctrl     = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            ctrl.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               ctrl.load = 1'b1;
               unique case (status.item_cmd)
                  lpuic_pkg::CMD_CLASSIFY: state_in = S_SLOT_RD;
                  lpuic_pkg::CMD_READ:     state_in = S_READ;
                  lpuic_pkg::CMD_CLEAR:    state_in = S_CLEAR;
                  default: begin
                     ctrl.res_zero = 1'b1;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         S_SLOT_RD: begin
            state_in = S_SLOT_CHK;
         end
         S_SLOT_CHK: begin
            if (status.slot_empty) begin
               if (status.table_full) begin
                  ctrl.drop = 1'b1;
               end else begin
                  ctrl.insert = 1'b1;
               end
               state_in = S_DONE;
            end else begin
               state_in = S_KEY_CHK;
            end
         end
         S_KEY_CHK: begin
            if (status.key_match) begin
               ctrl.bump = 1'b1;
               state_in  = S_DONE;
            end else begin
               ctrl.probe_next = 1'b1;
               state_in        = S_SLOT_RD;
            end
         end
         S_READ: begin
            ctrl.read_res = 1'b1;
            state_in      = S_DONE;
         end
         S_CLEAR: begin
            ctrl.sweep = 1'b1;
            if (status.sweep_last) begin
               ctrl.reset_ids = 1'b1;
               ctrl.res_zero  = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               ctrl.out_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/lpuic_dp.sv
// datapath of the label pair id counter: hash slot memory, entry memory,
// next id, probe pointer, result and output registers; depends on lpuic_pkg
`default_nettype none

module lpuic_dp #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  lpuic_pkg::ctrl_cmd_type              ctrl,
   output lpuic_pkg::dp_status_type             status,
   input  wire [lpuic_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire [lpuic_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic [lpuic_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [lpuic_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int IW    = $clog2(TABLE_DEPTH + 2);
   localparam int HW    = AW + 1;
   localparam int SLOTS = 1 << HW;
   localparam int CW    = (IW > lpuic_pkg::FACE_ID_W) ? IW : lpuic_pkg::FACE_ID_W;

   typedef struct packed {
      logic [lpuic_pkg::LABEL_W-1:0] lower_label;
      logic [lpuic_pkg::LABEL_W-1:0] upper_label;
      logic [lpuic_pkg::COUNT_W-1:0] triangle_count;
   } entry_type;

   // xor fold of the ordered pair onto the slot index
   function automatic logic [HW-1:0] hash_key(input logic [31:0] lo, input logic [31:0] hi);
      logic [31:0]   x;
      logic [HW-1:0] h;
      x = lo ^ {hi[12:0], hi[31:13]};
      h = '0;
      for (int i = 0; i * HW < 32; i++) begin
         h = h ^ HW'(x >> (i * HW));
      end
      return h;
   endfunction

   // incoming beat
   logic [lpuic_pkg::LABEL_W-1:0]   in_a, in_b, in_lo, in_hi;
   logic [lpuic_pkg::FACE_ID_W-1:0] in_index;
   logic                            a_less;

   assign in_a     = req_tdata[31:0];
   assign in_b     = req_tdata[63:32];
   assign in_index = req_tdata[72:64];
   assign a_less   = $signed(in_a) < $signed(in_b);
   assign in_lo    = a_less ? in_a : in_b;
   assign in_hi    = a_less ? in_b : in_a;

   logic [lpuic_pkg::LABEL_W-1:0]   lo_ff, hi_ff;
   logic [lpuic_pkg::FACE_ID_W-1:0] idx_ff;
   logic [HW-1:0]                   ptr_ff, ptr_in;
   logic [HW-1:0]                   sweep_ff, sweep_in;
   logic [IW-1:0]                   next_id_ff, next_id_in;
   logic [IW-1:0]                   slot_q_ff;
   entry_type                       entry_q_ff;
   lpuic_pkg::result_type           res_ff, res_in;
   lpuic_pkg::result_type           out_ff;

   // hash slot memory: id of the pair parked there, zero when empty
   logic [IW-1:0] slot_mem [SLOTS];
   logic          slot_we;
   logic [HW-1:0] slot_waddr;
   logic [IW-1:0] slot_wdata;

   assign slot_we    = ctrl.insert || ctrl.sweep;
   assign slot_waddr = ctrl.sweep ? sweep_ff : ptr_ff;
   assign slot_wdata = ctrl.sweep ? '0 : next_id_ff;

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_q_ff <= slot_mem[ptr_ff];
   end

   // entry memory: pair and count of id k at address k-1
   entry_type     entry_mem [TABLE_DEPTH];
   logic          entry_we;
   logic [AW-1:0] entry_waddr, entry_raddr;
   entry_type     entry_wdata;
   logic [lpuic_pkg::COUNT_W-1:0] count_inc;

   assign count_inc = (entry_q_ff.triangle_count == lpuic_pkg::COUNT_MAX) ?
                      entry_q_ff.triangle_count :
                      entry_q_ff.triangle_count + lpuic_pkg::COUNT_W'(1);

   assign entry_we    = ctrl.insert || ctrl.bump;
   assign entry_waddr = ctrl.insert ? AW'(next_id_ff - IW'(1)) : AW'(slot_q_ff - IW'(1));
   assign entry_raddr = ctrl.load ? AW'(CW'(in_index) - CW'(1)) : AW'(slot_q_ff - IW'(1));

   always_comb begin
      entry_wdata.lower_label    = lo_ff;
      entry_wdata.upper_label    = hi_ff;
      entry_wdata.triangle_count = ctrl.insert ? lpuic_pkg::COUNT_W'(1) : count_inc;
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[entry_waddr] <= entry_wdata;
      end
      entry_q_ff <= entry_mem[entry_raddr];
   end

   // status toward the controller
   always_comb begin
      status.item_cmd   = req_tuser;
      status.slot_empty = (slot_q_ff == '0);
      status.key_match  = (entry_q_ff.lower_label == lo_ff) &&
                          (entry_q_ff.upper_label == hi_ff);
      status.table_full = CW'(next_id_ff) > CW'(TABLE_DEPTH);
      status.sweep_last = (sweep_ff == '1);
   end

   assign ptr_in = ctrl.load       ? hash_key(in_lo, in_hi) :
                   ctrl.probe_next ? ptr_ff + HW'(1) : ptr_ff;

   assign sweep_in = ctrl.sweep ? sweep_ff + HW'(1) : sweep_ff;

   always_comb begin
      next_id_in = next_id_ff;
      if (ctrl.reset_ids) begin
         next_id_in = IW'(1);
      end else if (ctrl.insert) begin
         next_id_in = next_id_ff + IW'(1);
      end
   end

   // result staging
   logic read_ok;
   assign read_ok = (idx_ff != '0) && (CW'(idx_ff) < CW'(next_id_ff));

   always_comb begin
      res_in = res_ff;
      if (ctrl.res_zero) begin
         res_in = '0;
      end else if (ctrl.drop) begin
         res_in             = '0;
         res_in.lower_label = lo_ff;
         res_in.upper_label = hi_ff;
         res_in.status      = lpuic_pkg::ST_FULL;
      end else if (ctrl.insert) begin
         res_in.face_id        = lpuic_pkg::FACE_ID_W'(next_id_ff);
         res_in.lower_label    = lo_ff;
         res_in.upper_label    = hi_ff;
         res_in.triangle_count = lpuic_pkg::COUNT_W'(1);
         res_in.is_new         = 1'b1;
         res_in.status         = lpuic_pkg::ST_OK;
      end else if (ctrl.bump) begin
         res_in.face_id        = lpuic_pkg::FACE_ID_W'(slot_q_ff);
         res_in.lower_label    = lo_ff;
         res_in.upper_label    = hi_ff;
         res_in.triangle_count = count_inc;
         res_in.is_new         = 1'b0;
         res_in.status         = lpuic_pkg::ST_OK;
      end else if (ctrl.read_res) begin
         res_in = '0;
         if (read_ok) begin
            res_in.face_id        = idx_ff;
            res_in.lower_label    = entry_q_ff.lower_label;
            res_in.upper_label    = entry_q_ff.upper_label;
            res_in.triangle_count = entry_q_ff.triangle_count;
         end else if (idx_ff != '0) begin
            res_in.face_id = idx_ff;
            res_in.status  = lpuic_pkg::ST_UNASSIGNED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff   <= '0;
         next_id_ff <= IW'(1);
      end else begin
         sweep_ff   <= sweep_in;
         next_id_ff <= next_id_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      res_ff <= res_in;
      if (ctrl.load) begin
         lo_ff  <= in_lo;
         hi_ff  <= in_hi;
         idx_ff <= in_index;
      end
      if (ctrl.out_load) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_tdata = {out_ff.triangle_count, out_ff.upper_label,
                       out_ff.lower_label, out_ff.face_id};
   assign rsp_tuser = {out_ff.status, out_ff.is_new};

endmodule

`default_nettype wire

FILE: sv/label_pair_unique_id_counter.sv
// label pair id counter: orders a label pair, finds or assigns its id and
// counts triangles per pair; one result beat for every request beat.
// requests enter on req_*, results leave on rsp_*, both stream handshakes.
// req_tuser is the command: classify a triangle, read an entry, clear.
// the pair is found through a hashed slot memory of 2 * 2**ceil(log2(TABLE_DEPTH))
// slots with linear probing, each probe being a slot read and an entry read.
// a classify beat reads its hash slot and, if it is occupied, checks the
// entry key: a matching pair raises its count, a mismatch probes the next
// slot, and an empty slot takes a new pair unless the table is full. a read
// beat reads its entry; an unknown command gives an all-zero result. clear
// wipes one slot per cycle over the whole slot memory, then resets next id.
// after reset the slot memory is wiped in the same way before req_tready
// rises; next id starts at one.
// a finished result waits in the output register while the next request
// is taken; with rsp_tready low the block stalls once a second result is
// ready and holds it until the output register frees up.
// depends on lpuic_pkg, lpuic_ctrl, lpuic_dp
`default_nettype none

module label_pair_unique_id_counter #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // label_a [31:0], label_b [63:32], entry_index [72:64], zero fill
   input  wire [lpuic_pkg::REQ_DATA_W-1:0]      req_tdata,
   // command [1:0]
   input  wire [lpuic_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // face_id [8:0], lower_label [40:9], upper_label [72:41],
   // triangle_count [103:73]
   output logic [lpuic_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // is_new [0], status [2:1]
   output logic [lpuic_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   lpuic_pkg::ctrl_cmd_type  ctrl;
   lpuic_pkg::dp_status_type status;

   lpuic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   lpuic_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // a new result never lands on a beat that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten");

   // memory writes and result sources are mutually exclusive
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.insert, ctrl.bump, ctrl.drop, ctrl.read_res, ctrl.sweep}))
      else $error("conflicting datapath actions");

   // a pair is only placed into an empty slot while ids remain
   a_insert_ok: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |-> (status.slot_empty && !status.table_full))
      else $error("insert into occupied slot or full table");

   // once full, the table stays full until cleared
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (status.table_full && !ctrl.reset_ids) |=> status.table_full)
      else $error("table full flag dropped without clear");

endmodule

`default_nettype wire
